/* design/brm_pkg.sv */
// Package for the register machine execute core.
// Holds opcodes, status codes, shared widths and the structs passed between modules.
// No dependencies.
package brm_pkg;

  localparam int STORE_WORDS_DEF = 32;
  localparam logic [15:0] STEP_LIMIT_RST = 16'd100;

  localparam int IN_W   = 56;
  localparam int OUT_W  = 72;
  localparam int USER_W = 2;

  localparam logic [7:0] OP_END   = 8'd0;
  localparam logic [7:0] OP_MOV   = 8'd1;
  localparam logic [7:0] OP_PRINT = 8'd2;
  localparam logic [7:0] OP_MOVQ  = 8'd3;
  localparam logic [7:0] OP_ADD   = 8'd4;
  localparam logic [7:0] OP_SUB   = 8'd5;
  localparam logic [7:0] OP_MUL   = 8'd6;
  localparam logic [7:0] OP_EQ    = 8'd7;
  localparam logic [7:0] OP_NEQ   = 8'd8;
  localparam logic [7:0] OP_JMPIF = 8'd13;
  localparam logic [7:0] OP_JMP   = 8'd14;
  localparam logic [7:0] OP_LOAD  = 8'd15;
  localparam logic [7:0] OP_STORE = 8'd16;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_END     = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_ADDR    = 3'd3;
  localparam logic [2:0] ST_LIMIT   = 3'd4;
  localparam logic [2:0] ST_HALTED  = 3'd5;

  typedef struct packed {
    logic        en;
    logic [2:0]  addr;
    logic [31:0] data;
  } reg_wr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        print_valid;
    logic [31:0] print_value;
    logic        jump_taken;
    logic [31:0] jump_target;
    logic        halted;
  } result_t;

endpackage

/* design/brm_regfile.sv */
// Eight-entry 32-bit register file with two registered read ports.
// Reads bypass the write of the instruction executing in the same cycle.
// Depends on brm_pkg.
module brm_regfile (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [2:0]       ra_addr,
  input  logic [2:0]       rb_addr,
  input  brm_pkg::reg_wr_t wr,
  output logic [31:0]      ra_data,
  output logic [31:0]      rb_data
);
  import brm_pkg::*;

  logic [31:0] regs [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        regs[i] <= '0;
      end
    end else if (wr.en) begin
      regs[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ra_data <= (wr.en && wr.addr == ra_addr) ? wr.data : regs[ra_addr];
      rb_data <= (wr.en && wr.addr == rb_addr) ? wr.data : regs[rb_addr];
    end
  end

endmodule

/* design/brm_store.sv */
// Word store with one write port and one registered read port.
// After reset a clearing pass writes zero to every word, one word per cycle.
// Depends on brm_pkg.
module brm_store #(
  parameter int STORE_WORDS = brm_pkg::STORE_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           rd_en,
  input  logic [$clog2(STORE_WORDS)-1:0] rd_addr,
  input  logic                           wr_en,
  input  logic [$clog2(STORE_WORDS)-1:0] wr_addr,
  input  logic [31:0]                    wr_data,
  output logic [31:0]                    rd_data,
  output logic                           ready
);
  import brm_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);

  logic [31:0]   mem [STORE_WORDS];
  logic [31:0]   mem_rd;
  logic          fwd;
  logic [31:0]   fwd_data;
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == AW'(STORE_WORDS - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A store executing in the same cycle as the read wins over the old word.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_rd   <= mem[rd_addr];
      fwd      <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd ? fwd_data : mem_rd;
  assign ready   = !clr_busy;

endmodule

/* design/brm_exec.sv */
// Execute stage: decodes the opcode, computes the result word and the state writes,
// and holds the step counter, halt flag and step limit register. Depends on brm_pkg.
module brm_exec #(
  parameter int STORE_WORDS = brm_pkg::STORE_WORDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic [7:0]                     op,
  input  logic [2:0]                     dest_reg,
  input  logic [31:0]                    immediate,
  input  logic [31:0]                    ra_data,
  input  logic [31:0]                    rb_data,
  input  logic [31:0]                    ld_data,
  input  logic                           cfg_we,
  input  logic [15:0]                    cfg_value,
  output brm_pkg::result_t               res,
  output brm_pkg::reg_wr_t               reg_wr,
  output logic                           st_we,
  output logic [$clog2(STORE_WORDS)-1:0] st_addr,
  output logic [31:0]                    st_data
);
  import brm_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);

  logic        halt_flag;
  logic        halt_flag_next;
  logic [15:0] step_count;
  logic [15:0] step_count_next;
  logic [15:0] step_limit;
  logic        in_range;

  assign in_range = immediate < 32'(STORE_WORDS);
  assign st_addr  = immediate[AW-1:0];
  assign st_data  = ra_data;

  always_comb begin
    logic executed;
    logic wr_en;
    logic [31:0] wr_val;
    executed        = 1'b1;
    wr_en           = 1'b0;
    wr_val          = '0;
    res             = '0;
    res.status      = ST_OK;
    st_we           = 1'b0;
    step_count_next = step_count;
    halt_flag_next  = halt_flag;
    if (halt_flag) begin
      res.status = ST_HALTED;
      executed   = 1'b0;
    end else begin
      unique case (op)
        OP_END: begin
          res.status = ST_END;
          executed   = 1'b0;
        end
        OP_MOV:   begin wr_en = 1'b1; wr_val = ra_data; end
        OP_PRINT: begin
          res.print_valid = 1'b1;
          res.print_value = ra_data;
        end
        OP_MOVQ:  begin wr_en = 1'b1; wr_val = immediate; end
        OP_ADD:   begin wr_en = 1'b1; wr_val = ra_data + rb_data; end
        OP_SUB:   begin wr_en = 1'b1; wr_val = ra_data - rb_data; end
        OP_MUL:   begin wr_en = 1'b1; wr_val = ra_data * rb_data; end
        OP_EQ:    begin wr_en = 1'b1; wr_val = {31'd0, ra_data == rb_data}; end
        OP_NEQ:   begin wr_en = 1'b1; wr_val = {31'd0, ra_data != rb_data}; end
        OP_JMPIF: begin
          if (ra_data != '0) begin
            res.jump_taken  = 1'b1;
            res.jump_target = immediate;
          end
        end
        OP_JMP: begin
          res.jump_taken  = 1'b1;
          res.jump_target = immediate;
        end
        OP_LOAD, OP_STORE: begin
          if (!in_range) begin
            res.status = ST_ADDR;
            executed   = 1'b0;
          end else if (op == OP_LOAD) begin
            wr_en  = 1'b1;
            wr_val = ld_data;
          end else begin
            st_we = en;
          end
        end
        default: begin
          res.status = ST_UNKNOWN;
          executed   = 1'b0;
        end
      endcase
      if (executed) begin
        if (step_count != 16'hFFFF) begin
          step_count_next = step_count + 16'd1;
        end
        if (step_count_next >= step_limit) begin
          res.status     = ST_LIMIT;
          halt_flag_next = 1'b1;
        end
      end else begin
        halt_flag_next = 1'b1;
      end
    end
    res.halted  = halt_flag_next;
    reg_wr.en   = en && wr_en;
    reg_wr.addr = dest_reg;
    reg_wr.data = wr_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      halt_flag  <= 1'b0;
      step_count <= '0;
    end else if (en) begin
      halt_flag  <= halt_flag_next;
      step_count <= step_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit <= STEP_LIMIT_RST;
    end else if (cfg_we) begin
      step_limit <= cfg_value;
    end
  end

endmodule

/* design/bytecode_register_machine_execute_core.sv */
// Top level of the register machine execute core.
// It instantiates the register file, the word store and the execute stage.
// Depends on brm_pkg, brm_regfile, brm_store and brm_exec.
//
// Usage: every word on the slave stream is one decoded instruction and yields
// exactly one result word on the master stream, in order. The configuration
// channel (cfg_valid, cfg_ready, cfg_data) writes the 16-bit step limit; it is
// always ready and should only be written while no instruction is in flight.
// From acceptance to the result being offered, the operand stage first registers
// the operands read from the register file and the word store, then the execute
// stage computes the result and loads the output register. Throughput is one
// instruction per cycle while the receiver does not stall; a result of one
// instruction is bypassed straight into the operand registers of the next, so
// dependent instructions run back to back. The execute stage (the 32x32
// multiplier into the bypass mux) sets the clock. After reset the word store
// is cleared one word per cycle; s_axis_tready stays low until that pass
// finishes. The registers are zero, the step count is zero and the step
// limit is 100. When the receiver stalls, the output register holds its word;
// a full operand stage drops s_axis_tready, an empty one takes one more word first.
module bytecode_register_machine_execute_core #(
  parameter int STORE_WORDS = brm_pkg::STORE_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // op[7:0], dest_reg[10:8], src_a[13:11], src_b[16:14], immediate[48:17], zeros
  input  logic [brm_pkg::IN_W-1:0]     s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // status[2:0], print_value[34:3], jump_target[66:35], halted[67], zeros
  output logic [brm_pkg::OUT_W-1:0]    m_axis_tdata,
  // print_valid[0], jump_taken[1]
  output logic [brm_pkg::USER_W-1:0]   m_axis_tuser,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [15:0]                  cfg_data
);
  import brm_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);

  // Unpacked input fields.
  logic [7:0]  in_op;
  logic [2:0]  in_dest;
  logic [2:0]  in_src_a;
  logic [2:0]  in_src_b;
  logic [31:0] in_imm;
  logic        in_uses_dest;
  logic [2:0]  in_ra_addr;

  assign in_op    = s_axis_tdata[7:0];
  assign in_dest  = s_axis_tdata[10:8];
  assign in_src_a = s_axis_tdata[13:11];
  assign in_src_b = s_axis_tdata[16:14];
  assign in_imm   = s_axis_tdata[48:17];

  // Print, jump-if and store read the register named by dest_reg; everything
  // else reads src_a on the first port. The second port always reads src_b.
  assign in_uses_dest = (in_op == OP_PRINT) || (in_op == OP_JMPIF) || (in_op == OP_STORE);
  assign in_ra_addr   = in_uses_dest ? in_dest : in_src_a;

  // Operand stage registers.
  logic        s1_valid;
  logic [7:0]  s1_op;
  logic [2:0]  s1_dest;
  logic [31:0] s1_imm;

  logic        s1_adv;
  logic        in_accept;
  logic        exec_en;
  logic        store_ready;

  logic [31:0] ra_data;
  logic [31:0] rb_data;
  logic [31:0] ld_data;
  reg_wr_t     reg_wr;
  logic        st_we;
  logic [AW-1:0] st_addr;
  logic [31:0] st_data;
  result_t     res;

  // Output register.
  logic        out_valid;
  result_t     out_res;

  // The operand stage moves on whenever the output register is empty or drained.
  assign s1_adv        = !out_valid || m_axis_tready;
  assign s_axis_tready = store_ready && (!s1_valid || s1_adv);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign exec_en       = s1_valid && s1_adv;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op   <= in_op;
      s1_dest <= in_dest;
      s1_imm  <= in_imm;
    end
  end

  brm_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .ra_addr (in_ra_addr),
    .rb_addr (in_src_b),
    .wr      (reg_wr),
    .ra_data (ra_data),
    .rb_data (rb_data)
  );

  brm_store #(
    .STORE_WORDS (STORE_WORDS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_accept),
    .rd_addr (in_imm[AW-1:0]),
    .wr_en   (st_we),
    .wr_addr (st_addr),
    .wr_data (st_data),
    .rd_data (ld_data),
    .ready   (store_ready)
  );

  brm_exec #(
    .STORE_WORDS (STORE_WORDS)
  ) u_exec (
    .clk       (clk),
    .rst       (rst),
    .en        (exec_en),
    .op        (s1_op),
    .dest_reg  (s1_dest),
    .immediate (s1_imm),
    .ra_data   (ra_data),
    .rb_data   (rb_data),
    .ld_data   (ld_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .res       (res),
    .reg_wr    (reg_wr),
    .st_we     (st_we),
    .st_addr   (st_addr),
    .st_data   (st_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_res.halted, out_res.jump_target,
                          out_res.print_value, out_res.status};
  assign m_axis_tuser  = {out_res.jump_taken, out_res.print_valid};

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for bytecode_register_machine_execute_core.
// Drives decoded instructions, predicts every result word and compares it.
// Depends on brm_pkg and the core's RTL only.
module tb_top;
  import brm_pkg::*;

  localparam int WORDS = STORE_WORDS_DEF;
  localparam int AW    = $clog2(WORDS);

  // One decoded instruction. The packed layout puts op in the lowest bits,
  // which is exactly the slave tdata layout once padded to 56 bits.
  typedef struct packed {
    logic [31:0] imm;
    logic [2:0]  src_b;
    logic [2:0]  src_a;
    logic [2:0]  dest;
    logic [7:0]  op;
  } instr_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic [USER_W-1:0] m_axis_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [15:0]       cfg_data = '0;

  bytecode_register_machine_execute_core #(
    .STORE_WORDS(WORDS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Architectural copy of the machine, advanced once per accepted word.
  logic [31:0] arch_regs [8] = '{default: '0};
  logic [31:0] arch_store [WORDS] = '{default: '0};
  logic [15:0] arch_steps = '0;
  logic [15:0] arch_limit = STEP_LIMIT_RST;
  logic        arch_halted = 1'b0;

  instr_t  pending_words [$];
  result_t predicted_results [$];
  instr_t  cur_instr;
  int      words_sent = 0;
  int      results_seen = 0;
  int      errors = 0;

  // Burst and gap bookkeeping for the sender.
  int burst_left = 0;
  int gap_left = 0;

  // Receiver stall pattern: the mode is redrawn whenever its countdown runs out.
  int stall_mode = 0;
  int mode_left = 0;
  int stall_period = 2;
  int stall_phase = 0;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Executes one instruction on the architectural copy and returns the
  // result word the core must produce for it.
  function automatic result_t execute_instr(input instr_t ins);
    result_t r;
    logic    ran;
    r = '0;
    ran = 1'b1;
    if (arch_halted) begin
      // A halted machine ignores everything until reset.
      r.status = ST_HALTED;
    end else begin
      case (ins.op)
        OP_END: begin
          r.status = ST_END;
          ran = 1'b0;
        end
        OP_MOV:   arch_regs[ins.dest] = arch_regs[ins.src_a];
        OP_PRINT: begin
          r.print_valid = 1'b1;
          r.print_value = arch_regs[ins.dest];
        end
        OP_MOVQ:  arch_regs[ins.dest] = ins.imm;
        OP_ADD:   arch_regs[ins.dest] = arch_regs[ins.src_a] + arch_regs[ins.src_b];
        OP_SUB:   arch_regs[ins.dest] = arch_regs[ins.src_a] - arch_regs[ins.src_b];
        OP_MUL:   arch_regs[ins.dest] = arch_regs[ins.src_a] * arch_regs[ins.src_b];
        OP_EQ:    arch_regs[ins.dest] = {31'b0, arch_regs[ins.src_a] == arch_regs[ins.src_b]};
        OP_NEQ:   arch_regs[ins.dest] = {31'b0, arch_regs[ins.src_a] != arch_regs[ins.src_b]};
        OP_JMPIF: begin
          if (arch_regs[ins.dest] != 32'd0) begin
            r.jump_taken = 1'b1;
            r.jump_target = ins.imm;
          end
        end
        OP_JMP: begin
          r.jump_taken = 1'b1;
          r.jump_target = ins.imm;
        end
        OP_LOAD, OP_STORE: begin
          // The word index is unsigned, so negative immediates land here too.
          if (ins.imm >= 32'(WORDS)) begin
            r.status = ST_ADDR;
            ran = 1'b0;
          end else if (ins.op == OP_LOAD) begin
            arch_regs[ins.dest] = arch_store[ins.imm[AW-1:0]];
          end else begin
            arch_store[ins.imm[AW-1:0]] = arch_regs[ins.dest];
          end
        end
        default: begin
          r.status = ST_UNKNOWN;
          ran = 1'b0;
        end
      endcase
      if (ran) begin
        // The step count saturates; the limit check follows every executed
        // instruction and keeps its print and jump outputs.
        if (arch_steps != 16'hFFFF) arch_steps++;
        if (arch_steps >= arch_limit) begin
          r.status = ST_LIMIT;
          arch_halted = 1'b1;
        end
      end else begin
        arch_halted = 1'b1;
      end
    end
    r.halted = arch_halted;
    return r;
  endfunction

  // Operand values that favor the wrap-around corners.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // A well-formed instruction that never halts the machine by itself.
  function automatic instr_t random_safe_instr();
    instr_t ins;
    int     pick;
    ins.dest  = 3'($urandom_range(0, 7));
    ins.src_a = 3'($urandom_range(0, 7));
    ins.src_b = 3'($urandom_range(0, 7));
    // Equal sources make the comparisons come out true now and then.
    if ($urandom_range(0, 3) == 0) ins.src_b = ins.src_a;
    ins.imm = pick_value();
    pick = $urandom_range(0, 99);
    if (pick < 14)      ins.op = OP_MOVQ;
    else if (pick < 22) ins.op = OP_MOV;
    else if (pick < 32) ins.op = OP_ADD;
    else if (pick < 40) ins.op = OP_SUB;
    else if (pick < 48) ins.op = OP_MUL;
    else if (pick < 54) ins.op = OP_EQ;
    else if (pick < 60) ins.op = OP_NEQ;
    else if (pick < 70) ins.op = OP_PRINT;
    else if (pick < 76) ins.op = OP_JMPIF;
    else if (pick < 80) ins.op = OP_JMP;
    else if (pick < 90) ins.op = OP_LOAD;
    else                ins.op = OP_STORE;
    if (ins.op == OP_LOAD || ins.op == OP_STORE) ins.imm = 32'($urandom_range(0, WORDS - 1));
    return ins;
  endfunction

  task automatic queue_word(input logic [7:0] op, input logic [2:0] d, input logic [2:0] a,
                            input logic [2:0] b, input logic [31:0] imm);
    instr_t ins;
    ins = '{imm: imm, src_b: b, src_a: a, dest: d, op: op};
    pending_words.push_back(ins);
    words_sent++;
  endtask

  task automatic queue_instr(input instr_t ins);
    pending_words.push_back(ins);
    words_sent++;
  endtask

  // Blocks until every queued word has produced its result, then lets the
  // two-stage pipeline settle.
  task automatic wait_idle();
    while (results_seen < words_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The configuration channel is only used while the core is idle, so the
  // predicted limit can change as soon as the write is accepted.
  task automatic write_step_limit(input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    arch_limit = value;
  endtask

  // Sender: feeds pending instructions in bursts separated by random gaps.
  // The prediction is made at the edge where the word is accepted.
  always @(posedge clk) begin : sender
    logic next_valid;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predicted_results.push_back(execute_instr(cur_instr));
      if (!s_axis_tvalid || s_axis_tready) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() != 0) begin
          cur_instr = pending_words.pop_front();
          s_axis_tdata <= {{(IN_W - $bits(instr_t)){1'b0}}, cur_instr};
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            // A third of the bursts run straight into the next one.
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end
        s_axis_tvalid <= next_valid;
      end
    end
  end

  // Receiver: stall pattern plus the result check against the oldest
  // prediction.
  always @(posedge clk) begin : receiver
    result_t want;
    result_t got;
    logic    ready_next;
    if (mode_left <= 0) begin
      stall_mode   = $urandom_range(0, 2);
      mode_left    = $urandom_range(64, 256);
      stall_period = $urandom_range(2, 6);
    end
    mode_left--;
    stall_phase = (stall_phase + 1) % stall_period;
    case (stall_mode)
      0:       ready_next = 1'b1;
      1:       ready_next = ($urandom_range(0, 3) != 0);
      default: ready_next = (stall_phase == 0);
    endcase
    m_axis_tready <= ready_next;

    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      got.status      = m_axis_tdata[2:0];
      got.print_value = m_axis_tdata[34:3];
      got.jump_target = m_axis_tdata[66:35];
      got.halted      = m_axis_tdata[67];
      got.print_valid = m_axis_tuser[0];
      got.jump_taken  = m_axis_tuser[1];
      if (predicted_results.size() == 0) begin
        flag_error("result word with no instruction waiting for it");
      end else begin
        want = predicted_results.pop_front();
        if (got.status != want.status)
          flag_error($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.print_valid != want.print_valid)
          flag_error($sformatf("print_valid got %0b want %0b", got.print_valid,
                               want.print_valid));
        if (got.print_value != want.print_value)
          flag_error($sformatf("print_value got %h want %h", got.print_value,
                               want.print_value));
        if (got.jump_taken != want.jump_taken)
          flag_error($sformatf("jump_taken got %0b want %0b", got.jump_taken,
                               want.jump_taken));
        if (got.jump_target != want.jump_target)
          flag_error($sformatf("jump_target got %h want %h", got.jump_target,
                               want.jump_target));
        if (got.halted != want.halted)
          flag_error($sformatf("halted got %0b want %0b", got.halted, want.halted));
      end
    end
  end

  // Hard stop if the core hangs; a clean run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Main sequence. Reset happens once, so the machine can halt only once:
  // every phase keeps the program well-formed until the closing phase, which
  // halts it by one randomly chosen cause and then checks that it stays halted.
  initial begin : stimulus
    int       halt_cause;
    instr_t   ins;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset step limit: arithmetic corners, both
    // outcomes of the comparisons, the store ends and an unwritten word,
    // and jumps taken and not taken.
    queue_word(OP_MOVQ,  3'd0, 3'd0, 3'd0, 32'h7FFF_FFFF);
    queue_word(OP_MOVQ,  3'd1, 3'd7, 3'd7, 32'h8000_0000);
    queue_word(OP_MOVQ,  3'd2, 3'd0, 3'd0, 32'hFFFF_FFFF);
    queue_word(OP_MOVQ,  3'd3, 3'd0, 3'd0, 32'h0000_0001);
    queue_word(OP_ADD,   3'd4, 3'd0, 3'd3, 32'h0);   // largest plus one wraps
    queue_word(OP_SUB,   3'd5, 3'd1, 3'd3, 32'h0);   // smallest minus one wraps
    queue_word(OP_MUL,   3'd6, 3'd0, 3'd0, 32'h0);
    queue_word(OP_MUL,   3'd7, 3'd2, 3'd1, 32'h0);
    queue_word(OP_EQ,    3'd4, 3'd0, 3'd0, 32'h0);
    queue_word(OP_EQ,    3'd5, 3'd0, 3'd1, 32'h0);
    queue_word(OP_NEQ,   3'd6, 3'd2, 3'd1, 32'h0);
    queue_word(OP_NEQ,   3'd7, 3'd3, 3'd3, 32'h0);   // leaves r7 at zero
    queue_word(OP_MOV,   3'd3, 3'd2, 3'd0, 32'h0);
    queue_word(OP_PRINT, 3'd3, 3'd0, 3'd0, 32'h0);
    queue_word(OP_PRINT, 3'd0, 3'd7, 3'd7, 32'hFFFF_FFFF);
    queue_word(OP_STORE, 3'd1, 3'd0, 3'd0, 32'h0);
    queue_word(OP_STORE, 3'd0, 3'd0, 3'd0, 32'(WORDS - 1));
    queue_word(OP_LOAD,  3'd5, 3'd0, 3'd0, 32'(WORDS - 1));
    queue_word(OP_LOAD,  3'd6, 3'd0, 3'd0, 32'd5);   // never written, reads zero
    queue_word(OP_LOAD,  3'd2, 3'd0, 3'd0, 32'h0);
    queue_word(OP_PRINT, 3'd5, 3'd0, 3'd0, 32'h0);
    queue_word(OP_JMP,   3'd0, 3'd0, 3'd0, 32'hFFFF_FFFC);
    queue_word(OP_JMP,   3'd7, 3'd7, 3'd7, 32'h7FFF_FFFF);
    queue_word(OP_JMPIF, 3'd0, 3'd0, 3'd0, 32'h8000_0000);
    queue_word(OP_JMPIF, 3'd7, 3'd0, 3'd0, 32'h0000_0010);
    queue_word(OP_PRINT, 3'd6, 3'd0, 3'd0, 32'h0);
    wait_idle();

    // Random programs. The limit is raised well past what each phase needs,
    // starting at the top of its range.
    write_step_limit(16'hFFFF);
    for (int phase = 0; phase < 5; phase++) begin
      if (phase != 0) write_step_limit(16'($urandom_range(int'(arch_steps) + 300, 65535)));
      for (int n = 0; n < 215; n++) queue_instr(random_safe_instr());
      wait_idle();
    end

    // Closing phase: halt by end of program, an unknown opcode, a bad word
    // address, or the step limit.
    halt_cause = $urandom_range(0, 3);
    if (halt_cause == 3) begin
      // Either a limit of one, already passed, or one a few steps ahead.
      if ($urandom_range(0, 1) == 0) write_step_limit(16'd1);
      else write_step_limit(arch_steps + 16'($urandom_range(1, 10)));
      for (int n = 0; n < 12; n++) queue_instr(random_safe_instr());
    end else begin
      for (int n = 0; n < 8; n++) queue_instr(random_safe_instr());
      ins = random_safe_instr();
      if (halt_cause == 0) begin
        ins.op = OP_END;
      end else if (halt_cause == 1) begin
        ins.op = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(9, 12))
                                             : 8'($urandom_range(17, 255));
      end else begin
        ins.op  = ($urandom_range(0, 1) == 0) ? OP_LOAD : OP_STORE;
        ins.imm = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(WORDS, 32'h7FFF_FFFF))
                                              : (32'h8000_0000 | $urandom);
      end
      queue_instr(ins);
    end

    // Anything goes once halted: fully random fields.
    for (int n = 0; n < 30; n++) begin
      ins.dest  = 3'($urandom_range(0, 7));
      ins.src_a = 3'($urandom_range(0, 7));
      ins.src_b = 3'($urandom_range(0, 7));
      ins.imm   = $urandom;
      ins.op    = 8'($urandom_range(0, 255));
      queue_instr(ins);
    end
    wait_idle();
    write_step_limit(16'd1);
    for (int n = 0; n < 5; n++) queue_instr(random_safe_instr());
    wait_idle();

    repeat (8) @(posedge clk);
    if (predicted_results.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived", predicted_results.size()));
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
design/brm_pkg.sv
design/brm_regfile.sv
design/brm_store.sv
design/brm_exec.sv
design/bytecode_register_machine_execute_core.sv
tb/tb_top.sv
